/* hw/rtl/pis_pkg.sv */
// shared types, constants and solve program for the pairwise interaction score block
package pis_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int SUM_W         = 64;
  localparam int BW            = 288;
  localparam int LIMB_W        = 32;
  localparam int LIMBS         = 5;
  localparam int MAG_W         = LIMBS * LIMB_W;
  localparam int SHIFT         = 32 - FRACTION_BITS;
  localparam int NOPS          = 27;
  localparam int PC_W          = $clog2(NOPS);
  localparam int LIMB_IW       = $clog2(LIMBS);
  localparam int DIV_STEPS     = BW;
  localparam int DIV_CW        = $clog2(DIV_STEPS);
  localparam int SCORE_W       = 63;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_ACCUM,
    DP_LOAD_A,
    DP_LOAD_B,
    DP_STEP,
    DP_FINISH,
    DP_DIV_START,
    DP_DIV_STEP,
    DP_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    SRC_S0, SRC_S1, SRC_S2, SRC_S3, SRC_S4, SRC_S5, SRC_S6, SRC_S7, SRC_S8,
    SRC_C00, SRC_C01, SRC_C02, SRC_C11, SRC_C12, SRC_C22, SRC_T
  } src_t;

  typedef enum logic [3:0] {
    DST_C00, DST_C01, DST_C02, DST_C11, DST_C12, DST_C22, DST_T, DST_DET, DST_NUM
  } dst_t;

  typedef struct packed {
    src_t a;
    src_t b;
    dst_t dst;
    logic clr;
    logic neg;
    logic dbl;
  } prog_t;

  typedef struct packed {
    dp_op_t               op;
    src_t                 src;
    dst_t                 dst;
    logic                 clr;
    logic                 neg;
    logic                 dbl;
    logic [LIMB_IW-1:0]   li;
    logic [LIMB_IW-1:0]   lj;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic skip_div;
  } dp_status_t;

  function automatic prog_t mk(src_t a, src_t b, dst_t d, logic c, logic n, logic x);
    prog_t p;
    p.a = a; p.b = b; p.dst = d; p.clr = c; p.neg = n; p.dbl = x;
    return p;
  endfunction

  // adjugate, determinant, then quadratic form
  function automatic prog_t prog_entry(logic [PC_W-1:0] pc);
    prog_t p;
    case (pc)
      5'd0:  p = mk(SRC_S6, SRC_S8,  DST_C00, 1'b1, 1'b0, 1'b0);
      5'd1:  p = mk(SRC_S7, SRC_S7,  DST_C00, 1'b0, 1'b1, 1'b0);
      5'd2:  p = mk(SRC_S5, SRC_S7,  DST_C01, 1'b1, 1'b0, 1'b0);
      5'd3:  p = mk(SRC_S4, SRC_S8,  DST_C01, 1'b0, 1'b1, 1'b0);
      5'd4:  p = mk(SRC_S4, SRC_S7,  DST_C02, 1'b1, 1'b0, 1'b0);
      5'd5:  p = mk(SRC_S5, SRC_S6,  DST_C02, 1'b0, 1'b1, 1'b0);
      5'd6:  p = mk(SRC_S3, SRC_S8,  DST_C11, 1'b1, 1'b0, 1'b0);
      5'd7:  p = mk(SRC_S5, SRC_S5,  DST_C11, 1'b0, 1'b1, 1'b0);
      5'd8:  p = mk(SRC_S4, SRC_S5,  DST_C12, 1'b1, 1'b0, 1'b0);
      5'd9:  p = mk(SRC_S3, SRC_S7,  DST_C12, 1'b0, 1'b1, 1'b0);
      5'd10: p = mk(SRC_S3, SRC_S6,  DST_C22, 1'b1, 1'b0, 1'b0);
      5'd11: p = mk(SRC_S4, SRC_S4,  DST_C22, 1'b0, 1'b1, 1'b0);
      5'd12: p = mk(SRC_S3, SRC_C00, DST_DET, 1'b1, 1'b0, 1'b0);
      5'd13: p = mk(SRC_S4, SRC_C01, DST_DET, 1'b0, 1'b0, 1'b0);
      5'd14: p = mk(SRC_S5, SRC_C02, DST_DET, 1'b0, 1'b0, 1'b0);
      5'd15: p = mk(SRC_S0, SRC_S0,  DST_T,   1'b1, 1'b0, 1'b0);
      5'd16: p = mk(SRC_T,  SRC_C00, DST_NUM, 1'b1, 1'b0, 1'b0);
      5'd17: p = mk(SRC_S1, SRC_S1,  DST_T,   1'b1, 1'b0, 1'b0);
      5'd18: p = mk(SRC_T,  SRC_C11, DST_NUM, 1'b0, 1'b0, 1'b0);
      5'd19: p = mk(SRC_S2, SRC_S2,  DST_T,   1'b1, 1'b0, 1'b0);
      5'd20: p = mk(SRC_T,  SRC_C22, DST_NUM, 1'b0, 1'b0, 1'b0);
      5'd21: p = mk(SRC_S0, SRC_S1,  DST_T,   1'b1, 1'b0, 1'b0);
      5'd22: p = mk(SRC_T,  SRC_C01, DST_NUM, 1'b0, 1'b0, 1'b1);
      5'd23: p = mk(SRC_S0, SRC_S2,  DST_T,   1'b1, 1'b0, 1'b0);
      5'd24: p = mk(SRC_T,  SRC_C02, DST_NUM, 1'b0, 1'b0, 1'b1);
      5'd25: p = mk(SRC_S1, SRC_S2,  DST_T,   1'b1, 1'b0, 1'b0);
      5'd26: p = mk(SRC_T,  SRC_C12, DST_NUM, 1'b0, 1'b0, 1'b1);
      default: p = mk(SRC_S0, SRC_S0, DST_T, 1'b1, 1'b0, 1'b0);
    endcase
    return p;
  endfunction

endpackage

/* hw/rtl/pis_if.sv */
// sample and result channel interfaces
interface pis_in_if;
  logic              valid;
  logic              ready;
  logic [9:0]        weight;
  logic signed [9:0] residual;
  logic signed [9:0] x_first;
  logic signed [9:0] x_second;
  logic              last;
  modport source (output valid, weight, residual, x_first, x_second, last, input ready);
  modport sink   (input valid, weight, residual, x_first, x_second, last, output ready);
endinterface

interface pis_out_if;
  logic        valid;
  logic        ready;
  logic [62:0] score;
  logic        singular;
  modport source (output valid, score, singular, input ready);
  modport sink   (input valid, score, singular, output ready);
endinterface

/* hw/rtl/pis_datapath.sv */
// moment accumulators, limb multiplier, big accumulators and restoring divider
module pis_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  pis_pkg::dp_cmd_t    cmd,
  output pis_pkg::dp_status_t status,
  input  logic [9:0]          weight,
  input  logic signed [9:0]   residual,
  input  logic signed [9:0]   x_first,
  input  logic signed [9:0]   x_second,
  input  logic                last,
  output logic [pis_pkg::SCORE_W-1:0] score,
  output logic                singular
);

  localparam int BW = pis_pkg::BW;

  // sample capture and term stages
  logic signed [10:0] w_r, w1_r;
  logic signed [9:0]  r_r, a_r, b_r, a1_r, b1_r;
  logic               last_r;
  logic signed [19:0] wa1_r, ra1_r, rb1_r, ab1_r, bb1_r;
  logic signed [19:0] wa1_nxt, ra1_nxt, rb1_nxt, ab1_nxt, bb1_nxt;
  logic signed [29:0] t2, t3, t4;
  logic signed [39:0] t5, t7;
  logic signed [30:0] t6;
  logic signed [49:0] t8;
  logic signed [39:0] t5_r;
  logic [63:0] term_r [9];
  logic [63:0] sums_r [9];

  assign wa1_nxt = w_r * a_r;
  assign ra1_nxt = r_r * a_r;
  assign rb1_nxt = r_r * b_r;
  assign ab1_nxt = a_r * b_r;
  assign bb1_nxt = b_r * b_r;
  assign t2 = ra1_r * b1_r;
  assign t3 = wa1_r * a1_r;
  assign t4 = wa1_r * b1_r;
  assign t5 = wa1_r * ab1_r;
  assign t6 = w1_r * bb1_r;
  assign t7 = wa1_r * bb1_r;
  assign t8 = t5_r * b1_r;

  always_ff @(posedge clk) begin
    if (cmd.op == pis_pkg::DP_CAPTURE) begin
      w_r    <= $signed({1'b0, weight});
      r_r    <= residual;
      a_r    <= x_first;
      b_r    <= x_second;
      last_r <= last;
    end
    w1_r  <= w_r;
    a1_r  <= a_r;
    b1_r  <= b_r;
    wa1_r <= wa1_nxt;
    ra1_r <= ra1_nxt;
    rb1_r <= rb1_nxt;
    ab1_r <= ab1_nxt;
    bb1_r <= bb1_nxt;
    t5_r  <= t5;
    term_r[0] <= {{44{ra1_r[19]}}, ra1_r};
    term_r[1] <= {{44{rb1_r[19]}}, rb1_r};
    term_r[2] <= {{34{t2[29]}}, t2};
    term_r[3] <= {{34{t3[29]}}, t3};
    term_r[4] <= {{34{t4[29]}}, t4};
    term_r[5] <= {{24{t5[39]}}, t5};
    term_r[6] <= {{33{t6[30]}}, t6};
    term_r[7] <= {{24{t7[39]}}, t7};
    term_r[8] <= {{14{t8[49]}}, t8};
  end

  // saturating accumulation
  logic [64:0] sum_ext [9];
  logic [63:0] sums_nxt [9];
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      sum_ext[k] = {sums_r[k][63], sums_r[k]} + {term_r[k][63], term_r[k]};
      if (sum_ext[k][64] != sum_ext[k][63]) begin
        sums_nxt[k] = sum_ext[k][64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
        sums_nxt[k] = sum_ext[k][63:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 9; k++) sums_r[k] <= '0;
    end else if (cmd.op == pis_pkg::DP_ACCUM) begin
      for (int k = 0; k < 9; k++) sums_r[k] <= sums_nxt[k];
    end else if (cmd.op == pis_pkg::DP_OUT) begin
      for (int k = 0; k < 9; k++) sums_r[k] <= '0;
    end
  end

  // solve registers
  logic [BW-1:0] c00_r, c01_r, c02_r, c11_r, c12_r, c22_r, t_r, det_r, num_r;
  logic [pis_pkg::MAG_W-1:0] mag_a_r, mag_b_r;
  logic          sign_r;
  logic [BW-1:0] prod_r;
  logic [BW-1:0] opnd, opnd_mag, dst_val, term, new_val, pp_sh;
  logic [2*pis_pkg::LIMB_W-1:0] pp;

  always_comb begin
    case (cmd.src)
      pis_pkg::SRC_S0:  opnd = {{(BW-64){sums_r[0][63]}}, sums_r[0]};
      pis_pkg::SRC_S1:  opnd = {{(BW-64){sums_r[1][63]}}, sums_r[1]};
      pis_pkg::SRC_S2:  opnd = {{(BW-64){sums_r[2][63]}}, sums_r[2]};
      pis_pkg::SRC_S3:  opnd = {{(BW-64){sums_r[3][63]}}, sums_r[3]};
      pis_pkg::SRC_S4:  opnd = {{(BW-64){sums_r[4][63]}}, sums_r[4]};
      pis_pkg::SRC_S5:  opnd = {{(BW-64){sums_r[5][63]}}, sums_r[5]};
      pis_pkg::SRC_S6:  opnd = {{(BW-64){sums_r[6][63]}}, sums_r[6]};
      pis_pkg::SRC_S7:  opnd = {{(BW-64){sums_r[7][63]}}, sums_r[7]};
      pis_pkg::SRC_S8:  opnd = {{(BW-64){sums_r[8][63]}}, sums_r[8]};
      pis_pkg::SRC_C00: opnd = c00_r;
      pis_pkg::SRC_C01: opnd = c01_r;
      pis_pkg::SRC_C02: opnd = c02_r;
      pis_pkg::SRC_C11: opnd = c11_r;
      pis_pkg::SRC_C12: opnd = c12_r;
      pis_pkg::SRC_C22: opnd = c22_r;
      pis_pkg::SRC_T:   opnd = t_r;
      default:          opnd = '0;
    endcase
    opnd_mag = opnd[BW-1] ? (~opnd + 1'b1) : opnd;
  end

  always_comb begin
    case (cmd.dst)
      pis_pkg::DST_C00: dst_val = c00_r;
      pis_pkg::DST_C01: dst_val = c01_r;
      pis_pkg::DST_C02: dst_val = c02_r;
      pis_pkg::DST_C11: dst_val = c11_r;
      pis_pkg::DST_C12: dst_val = c12_r;
      pis_pkg::DST_C22: dst_val = c22_r;
      pis_pkg::DST_T:   dst_val = t_r;
      pis_pkg::DST_DET: dst_val = det_r;
      pis_pkg::DST_NUM: dst_val = num_r;
      default:          dst_val = '0;
    endcase
    term = (sign_r ^ cmd.neg) ? (~prod_r + 1'b1) : prod_r;
    if (cmd.dbl) term = {term[BW-2:0], 1'b0};
    new_val = (cmd.clr ? '0 : dst_val) + term;
  end

  assign pp = mag_a_r[cmd.li*pis_pkg::LIMB_W +: pis_pkg::LIMB_W]
            * mag_b_r[cmd.lj*pis_pkg::LIMB_W +: pis_pkg::LIMB_W];
  assign pp_sh = {{(BW-2*pis_pkg::LIMB_W){1'b0}}, pp}
               << {({1'b0, cmd.li} + {1'b0, cmd.lj}), 5'd0};

  always_ff @(posedge clk) begin
    case (cmd.op)
      pis_pkg::DP_LOAD_A: begin
        mag_a_r <= opnd_mag[pis_pkg::MAG_W-1:0];
        sign_r  <= opnd[BW-1];
        prod_r  <= '0;
      end
      pis_pkg::DP_LOAD_B: begin
        mag_b_r <= opnd_mag[pis_pkg::MAG_W-1:0];
        sign_r  <= sign_r ^ opnd[BW-1];
      end
      pis_pkg::DP_STEP: prod_r <= prod_r + pp_sh;
      pis_pkg::DP_FINISH: begin
        case (cmd.dst)
          pis_pkg::DST_C00: c00_r <= new_val;
          pis_pkg::DST_C01: c01_r <= new_val;
          pis_pkg::DST_C02: c02_r <= new_val;
          pis_pkg::DST_C11: c11_r <= new_val;
          pis_pkg::DST_C12: c12_r <= new_val;
          pis_pkg::DST_C22: c22_r <= new_val;
          pis_pkg::DST_T:   t_r   <= new_val;
          pis_pkg::DST_DET: det_r <= new_val;
          pis_pkg::DST_NUM: num_r <= new_val;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // restoring division, one quotient bit a beat of the divider
  logic [BW-1:0] dvd_r, rem_r;
  logic [63:0]   q_r;
  logic          sat_r;
  logic [BW:0]   rem_sh, rem_diff;
  logic          ge;
  logic          det_nonpos, num_nonpos;

  assign rem_sh     = {rem_r, dvd_r[BW-1]};
  assign rem_diff   = rem_sh - {1'b0, det_r};
  assign ge         = (rem_sh >= {1'b0, det_r});
  assign det_nonpos = det_r[BW-1] | (det_r == '0);
  assign num_nonpos = num_r[BW-1] | (num_r == '0);

  always_ff @(posedge clk) begin
    case (cmd.op)
      pis_pkg::DP_DIV_START: begin
        dvd_r <= num_r << pis_pkg::SHIFT;
        rem_r <= '0;
        q_r   <= '0;
        sat_r <= 1'b0;
      end
      pis_pkg::DP_DIV_STEP: begin
        dvd_r <= {dvd_r[BW-2:0], 1'b0};
        rem_r <= ge ? rem_diff[BW-1:0] : rem_sh[BW-1:0];
        q_r   <= {q_r[62:0], ge};
        if (q_r[62]) sat_r <= 1'b1;
      end
      default: ;
    endcase
  end

  logic [pis_pkg::SCORE_W-1:0] score_r;
  logic                        singular_r;
  always_ff @(posedge clk) begin
    if (cmd.op == pis_pkg::DP_OUT) begin
      singular_r <= det_nonpos;
      if (det_nonpos | num_nonpos) score_r <= '0;
      else if (sat_r)              score_r <= '1;
      else                         score_r <= q_r[pis_pkg::SCORE_W-1:0];
    end
  end

  assign score           = score_r;
  assign singular        = singular_r;
  assign status.last     = last_r;
  assign status.skip_div = det_nonpos | num_nonpos;

endmodule

/* hw/rtl/pis_controller.sv */
// sequencer for sample accumulation, solve program and division
module pis_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  pis_pkg::dp_status_t status,
  output pis_pkg::dp_cmd_t    cmd
);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_M1    = 12'b000000000010,
    ST_M2    = 12'b000000000100,
    ST_M3    = 12'b000000001000,
    ST_ACC   = 12'b000000010000,
    ST_LDA   = 12'b000000100000,
    ST_LDB   = 12'b000001000000,
    ST_STEP  = 12'b000010000000,
    ST_FIN   = 12'b000100000000,
    ST_CHECK = 12'b001000000000,
    ST_DIV   = 12'b010000000000,
    ST_DONE  = 12'b100000000000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [pis_pkg::PC_W-1:0]       pc_r, pc_nxt;
  logic [pis_pkg::LIMB_IW-1:0]    li_r, li_nxt, lj_r, lj_nxt;
  logic [pis_pkg::DIV_CW-1:0]     dcnt_r, dcnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  pis_pkg::prog_t                 ent;

  assign ent = pis_pkg::prog_entry(pc_r);

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    li_nxt        = li_r;
    lj_nxt        = lj_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd.op  = pis_pkg::DP_NOP;
    cmd.src = ent.a;
    cmd.dst = ent.dst;
    cmd.clr = ent.clr;
    cmd.neg = ent.neg;
    cmd.dbl = ent.dbl;
    cmd.li  = li_r;
    cmd.lj  = lj_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = pis_pkg::DP_CAPTURE;
          state_nxt = ST_M1;
        end
      end
      ST_M1: state_nxt = ST_M2;
      ST_M2: state_nxt = ST_M3;
      ST_M3: state_nxt = ST_ACC;
      ST_ACC: begin
        cmd.op = pis_pkg::DP_ACCUM;
        pc_nxt = '0;
        state_nxt = status.last ? ST_LDA : ST_IDLE;
      end
      ST_LDA: begin
        cmd.op    = pis_pkg::DP_LOAD_A;
        state_nxt = ST_LDB;
      end
      ST_LDB: begin
        cmd.op    = pis_pkg::DP_LOAD_B;
        cmd.src   = ent.b;
        li_nxt    = '0;
        lj_nxt    = '0;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        cmd.op = pis_pkg::DP_STEP;
        if (lj_r == pis_pkg::LIMB_IW'(pis_pkg::LIMBS - 1)) begin
          lj_nxt = '0;
          if (li_r == pis_pkg::LIMB_IW'(pis_pkg::LIMBS - 1)) state_nxt = ST_FIN;
          else li_nxt = li_r + 1'b1;
        end else begin
          lj_nxt = lj_r + 1'b1;
        end
      end
      ST_FIN: begin
        cmd.op = pis_pkg::DP_FINISH;
        if (pc_r == pis_pkg::PC_W'(pis_pkg::NOPS - 1)) begin
          state_nxt = ST_CHECK;
        end else begin
          pc_nxt    = pc_r + 1'b1;
          state_nxt = ST_LDA;
        end
      end
      ST_CHECK: begin
        if (status.skip_div) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.op    = pis_pkg::DP_DIV_START;
          dcnt_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.op = pis_pkg::DP_DIV_STEP;
        if (dcnt_r == pis_pkg::DIV_CW'(pis_pkg::DIV_STEPS - 1)) state_nxt = ST_DONE;
        else dcnt_nxt = dcnt_r + 1'b1;
      end
      ST_DONE: begin
        if (!(out_valid_r && !out_ready)) begin
          cmd.op        = pis_pkg::DP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      li_r        <= '0;
      lj_r        <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      li_r        <= li_nxt;
      lj_r        <= lj_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/pairwise_interaction_score_top.sv */
// top level of the pairwise interaction score block
// Samples of one feature pair stream in one beat at a time and are summed into nine
// saturating 64-bit moment accumulators; a sample that is not last goes through
// capture, three multiply stages and accumulate. A last sample then runs the exact
// solve: 27 signed products through one 32x32 limb multiplier (load both operands,
// step over every limb pair, finish), a check, a restoring divider (skipped when the
// matrix is singular or the form is not positive) and an output step. The result
// waits in an output register while the next pair's samples are taken; sums clear
// when the result is loaded.
module pairwise_interaction_score_top (
  input  logic  clk,
  input  logic  rst_n,
  pis_in_if.sink    in_bus,
  pis_out_if.source out_bus
);

  pis_pkg::dp_cmd_t    cmd;
  pis_pkg::dp_status_t status;

  pis_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .status    (status),
    .cmd       (cmd)
  );

  pis_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .weight   (in_bus.weight),
    .residual (in_bus.residual),
    .x_first  (in_bus.x_first),
    .x_second (in_bus.x_second),
    .last     (in_bus.last),
    .score    (out_bus.score),
    .singular (out_bus.singular)
  );

endmodule

/* dv/tb_pairwise_interaction_score_top.sv */
// self-checking testbench for the pairwise interaction score block
module tb_pairwise_interaction_score_top;

  localparam int  LIMIT_CYCLES = 2000000;
  localparam int  DRAIN_CYCLES = 1200;
  localparam int  TARGET_ITEMS = 450;
  localparam longint SUM_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MIN   = 64'sh8000_0000_0000_0000;

  typedef logic signed [383:0] wide_t;

  typedef struct {
    logic [9:0]        weight;
    logic signed [9:0] residual;
    logic signed [9:0] x_first;
    logic signed [9:0] x_second;
    logic              last;
  } sample_t;

  typedef struct {
    logic [62:0] score;
    logic        singular;
  } score_t;

  logic clk;
  logic rst_n;
  pis_in_if  in_bus();
  pis_out_if out_bus();

  pairwise_interaction_score_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  sample_t sample_q[$];
  score_t  score_q[$];
  sample_t cur_sample;
  longint  moments[9];
  int      gap_left;
  int      burst_left;
  int      stall_mode;
  int      stall_left;
  longint  cycle_cnt = 0;
  bit      failed;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic longint sat_sum(longint x, longint y);
    longint s;
    s = x + y;
    if (x >= 0 && y >= 0 && s < 0) return SUM_MAX;
    if (x < 0 && y < 0 && s >= 0) return SUM_MIN;
    return s;
  endfunction

  function automatic wide_t cofactor(longint x, longint y, longint u, longint v);
    wide_t wx, wy, wu, wv;
    wx = x; wy = y; wu = u; wv = v;
    return wx * wy - wu * wv;
  endfunction

  function automatic score_t solve_pair();
    wide_t  c00, c01, c02, c11, c12, c22, det, num, p0, p1, p2, m00, m01, m02;
    logic [383:0] dividend, quotient;
    score_t res;
    p0 = moments[0]; p1 = moments[1]; p2 = moments[2];
    m00 = moments[3]; m01 = moments[4]; m02 = moments[5];
    c00 = cofactor(moments[6], moments[8], moments[7], moments[7]);
    c01 = cofactor(moments[5], moments[7], moments[4], moments[8]);
    c02 = cofactor(moments[4], moments[7], moments[5], moments[6]);
    c11 = cofactor(moments[3], moments[8], moments[5], moments[5]);
    c12 = cofactor(moments[4], moments[5], moments[3], moments[7]);
    c22 = cofactor(moments[3], moments[6], moments[4], moments[4]);
    det = m00 * c00 + m01 * c01 + m02 * c02;
    res.score = '0;
    res.singular = 1'b0;
    if (det <= 0) begin
      res.singular = 1'b1;
      return res;
    end
    num = p0 * p0 * c00 + p1 * p1 * c11 + p2 * p2 * c22
        + 2 * p0 * p1 * c01 + 2 * p0 * p2 * c02 + 2 * p1 * p2 * c12;
    if (num <= 0) return res;
    dividend = num;
    dividend = dividend << pis_pkg::SHIFT;
    quotient = dividend / $unsigned(det);
    if (quotient > 384'h7FFF_FFFF_FFFF_FFFF) res.score = '1;
    else res.score = quotient[62:0];
    return res;
  endfunction

  function automatic void take_sample(sample_t s);
    longint w, r, a, b, wa;
    longint terms[9];
    w = s.weight; r = s.residual; a = s.x_first; b = s.x_second;
    wa = w * a;
    terms[0] = r * a;
    terms[1] = r * b;
    terms[2] = r * a * b;
    terms[3] = wa * a;
    terms[4] = wa * b;
    terms[5] = wa * a * b;
    terms[6] = w * b * b;
    terms[7] = wa * b * b;
    terms[8] = wa * a * b * b;
    for (int i = 0; i < 9; i++) moments[i] = sat_sum(moments[i], terms[i]);
    if (s.last) begin
      score_q.push_back(solve_pair());
      for (int i = 0; i < 9; i++) moments[i] = 0;
    end
  endfunction

  // driver: bursts of beats with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid    <= 1'b0;
      in_bus.weight   <= '0;
      in_bus.residual <= '0;
      in_bus.x_first  <= '0;
      in_bus.x_second <= '0;
      in_bus.last     <= 1'b0;
      gap_left        <= 0;
      burst_left      <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) take_sample(cur_sample);
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left > 0) begin
          in_bus.valid <= 1'b0;
          gap_left     <= gap_left - 1;
        end else if (sample_q.size() > 0) begin
          cur_sample = sample_q.pop_front();
          in_bus.valid    <= 1'b1;
          in_bus.weight   <= cur_sample.weight;
          in_bus.residual <= cur_sample.residual;
          in_bus.x_first  <= cur_sample.x_first;
          in_bus.x_second <= cur_sample.x_second;
          in_bus.last     <= cur_sample.last;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with its own stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_mode    <= 0;
      stall_left    <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (score_q.size() == 0) begin
          $error("unexpected result beat: score %0h singular %0b",
                 out_bus.score, out_bus.singular);
          failed = 1'b1;
        end else begin
          score_t e;
          e = score_q.pop_front();
          if (out_bus.score !== e.score) begin
            $error("score mismatch: expected %0h actual %0h", e.score, out_bus.score);
            failed = 1'b1;
          end
          if (out_bus.singular !== e.singular) begin
            $error("singular mismatch: expected %0b actual %0b",
                   e.singular, out_bus.singular);
            failed = 1'b1;
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(20, 3000);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= ($urandom_range(0, 1) == 1);
        2: out_bus.ready <= ($urandom_range(0, 7) == 0);
        default: out_bus.ready <= (cycle_cnt[5:3] != 3'd0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_sample(int w, int r, int a, int b, bit last);
    sample_t s;
    s.weight = 10'(w); s.residual = 10'(r); s.x_first = 10'(a); s.x_second = 10'(b);
    s.last = last;
    sample_q.push_back(s);
  endtask

  function automatic int pick_signed();
    case ($urandom_range(0, 9))
      0: return -512;
      1: return 511;
      2: return int'($urandom_range(0, 6)) - 3;
      default: return int'($urandom_range(0, 1023)) - 512;
    endcase
  endfunction

  function automatic int pick_weight();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1023;
      2: return int'($urandom_range(1, 3));
      default: return int'($urandom_range(0, 1023));
    endcase
  endfunction

  initial begin
    int n_items;
    int len;
    rst_n     = 1'b0;
    failed    = 1'b0;
    for (int i = 0; i < 9; i++) moments[i] = 0;

    // single sample pair at the extremes: rank one, singular
    add_sample(1023, -512, -512, 511, 1'b1);
    // zero weight: all weighted moments zero, singular
    add_sample(0, 511, 3, -7, 1'b0);
    add_sample(0, -512, -512, 511, 1'b0);
    add_sample(0, 100, 511, -512, 1'b1);
    // zero residual: form is zero on a full-rank matrix
    add_sample(1023, 0, 1, 0, 1'b0);
    add_sample(1023, 0, 0, 1, 1'b0);
    add_sample(1023, 0, 1, 1, 1'b0);
    add_sample(1023, 0, -3, 2, 1'b1);
    // tiny weights with large residuals give a large score without saturation
    add_sample(1, 511, 1, 0, 1'b0);
    add_sample(1, -512, 0, 1, 1'b0);
    add_sample(1, 511, 1, 1, 1'b1);
    // ordinary full-rank pair at the field extremes
    add_sample(1023, 511, 511, 511, 1'b0);
    add_sample(512, -512, -512, 511, 1'b0);
    add_sample(1023, 511, 511, -512, 1'b0);
    add_sample(700, -300, -512, -512, 1'b0);
    add_sample(1023, 511, 1, -1, 1'b1);
    n_items = sample_q.size();

    // random pairs, mostly short, a few long
    while (n_items < TARGET_ITEMS) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        add_sample(pick_weight(), pick_signed(), pick_signed(), pick_signed(), k == len - 1);
      end
      n_items += len;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (sample_q.size() > 0 || in_bus.valid) @(posedge clk);
    while (score_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/pis_pkg.sv
hw/rtl/pis_if.sv
hw/rtl/pis_datapath.sv
hw/rtl/pis_controller.sv
hw/rtl/pairwise_interaction_score_top.sv
dv/tb_pairwise_interaction_score_top.sv
